// ----- sv/ddmo_pkg.sv -----
// Shared types and codes for the differential-drive mixer and odometry block.
package ddmo_pkg;

    // Input action codes
    localparam logic [2:0] ACT_TWIST = 3'd0;
    localparam logic [2:0] ACT_TICK  = 3'd1;
    localparam logic [2:0] ACT_LEFT  = 3'd2;
    localparam logic [2:0] ACT_RIGHT = 3'd3;
    localparam logic [2:0] ACT_EMERG = 3'd4;

    // Report kinds
    localparam logic [2:0] RK_DUTY   = 3'd0;
    localparam logic [2:0] RK_LSTAT  = 3'd1;
    localparam logic [2:0] RK_RSTAT  = 3'd2;
    localparam logic [2:0] RK_LDISC  = 3'd3;
    localparam logic [2:0] RK_RDISC  = 3'd4;
    localparam logic [2:0] RK_ODOM   = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_WHEEL_DIST = 2'd0;
    localparam logic [1:0] CFG_TPM        = 2'd1;
    localparam logic [1:0] CFG_CMD_TO     = 2'd2;
    localparam logic [1:0] CFG_STAT_TO    = 2'd3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;
    localparam int          IN_DATA_W     = 168;
    localparam int          OUT_DATA_W    = 200;
    localparam int          QUEUE_DEPTH   = 4;

    // One queued request from the front part to the back part
    typedef struct packed {
        logic [2:0]         kind;
        logic               last;
        logic signed [15:0] left_duty;
        logic signed [15:0] right_duty;
        logic signed [15:0] temp;
        logic signed [15:0] curr;
        logic [3:0]         status;
        logic signed [33:0] d_fwd;
        logic signed [33:0] d_rot;
        logic [31:0]        dt;
        logic [31:0]        tpm;
        logic [31:0]        left_ticks;
        logic [31:0]        right_ticks;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_EVAL, F_EMIT} t_front_state;
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_SEND} t_back_state;

endpackage

// ----- sv/ddmo_queue.sv -----
// Short request queue between the front and back parts.
module ddmo_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ddmo_pkg::t_job i_wdata,
    output logic           o_full,
    input  logic           i_pop,
    output ddmo_pkg::t_job o_rdata,
    output logic           o_empty
);
    import ddmo_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

endmodule

// ----- sv/ddmo_front.sv -----
// Front part: input accept, configuration, mixer, timeouts and status pairing.
module ddmo_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [2:0]     i_action,
    input  logic [ddmo_pkg::IN_DATA_W-1:0] i_data,
    output logic           o_push,
    output ddmo_pkg::t_job o_job,
    input  logic           i_full
);
    import ddmo_pkg::*;

    localparam logic signed [57:0] DUTY_LIM = 58'sd8589934592;

    // Configuration
    logic [23:0] r_wd;
    logic [31:0] r_tpm, r_cto, r_sto;

    // Captured item
    logic [2:0]         r_act;
    logic [31:0]        r_now;
    logic signed [31:0] r_lin;
    logic               r_emer;
    logic signed [15:0] r_itemp, r_icur;
    logic [3:0]         r_istat;
    logic [31:0]        r_itacho;
    logic signed [56:0] r_p;

    // Block state
    logic signed [15:0] r_lspd, r_rspd, n_lspd, n_rspd;
    logic               r_duty_sent, n_duty_sent;
    logic [31:0]        r_lct, n_lct, r_lst, n_lst;
    logic [1:0]         r_sval, n_sval;
    logic signed [15:0] r_stemp [2], n_stemp [2];
    logic signed [15:0] r_scur [2], n_scur [2];
    logic [3:0]         r_scode [2], n_scode [2];
    logic [31:0]        r_stacho [2], n_stacho [2];
    logic               r_pvalid, n_pvalid;
    logic [31:0]        r_ptacho [2], n_ptacho [2];
    logic [31:0]        r_ptime, n_ptime;

    // Staged requests
    t_job         r_stage [3], n_stage [3];
    logic [1:0]   r_cnt, n_cnt, r_idx;
    t_front_state r_state, n_state;

    function automatic logic signed [15:0] to_duty(input logic signed [57:0] s);
        logic signed [57:0] t;
        begin
            t = s + ((s < 0) ? 58'sd524287 : 58'sd0);
            if (s >= DUTY_LIM) to_duty = 16'sd16384;
            else if (s <= -DUTY_LIM) to_duty = -16'sd16384;
            else to_duty = t[34:19];
        end
    endfunction

    function automatic t_job mk(input logic [2:0] kind);
        t_job j;
        begin
            j = '0;
            j.kind = kind;
            mk = j;
        end
    endfunction

    // Evaluate the captured item
    always_comb begin
        t_job               e;
        logic [1:0]         k;
        logic               s;
        logic [31:0]        dt;
        logic signed [31:0] dl, dr;
        logic signed [57:0] lin_x, s_l, s_r;
        n_lspd = r_lspd; n_rspd = r_rspd; n_duty_sent = r_duty_sent;
        n_lct = r_lct; n_lst = r_lst; n_sval = r_sval;
        n_stemp = r_stemp; n_scur = r_scur; n_scode = r_scode; n_stacho = r_stacho;
        n_pvalid = r_pvalid; n_ptacho = r_ptacho; n_ptime = r_ptime;
        n_stage = r_stage;
        k = 2'd0;
        s = r_act[0];
        dt = r_now - r_ptime;
        lin_x = 58'(r_lin) <<< 17;
        s_l = lin_x - 58'(r_p);
        s_r = -(lin_x + 58'(r_p));
        dl = '0;
        dr = '0;
        e = '0;
        if (r_state == F_EVAL) begin
            unique case (r_act)
                ACT_TWIST: begin
                    n_lct = r_now;
                    n_lspd = to_duty(s_l);
                    n_rspd = to_duty(s_r);
                    if (!r_duty_sent) begin
                        e = mk(RK_DUTY);
                        if (!r_emer) begin
                            e.left_duty = n_lspd;
                            e.right_duty = n_rspd;
                        end
                        n_stage[k] = e;
                        k = k + 2'd1;
                        n_duty_sent = 1'b1;
                    end
                end
                ACT_TICK: begin
                    if ((r_now - r_lct) > r_cto) begin
                        n_lspd = '0;
                        n_rspd = '0;
                    end
                    if (!r_duty_sent) begin
                        e = mk(RK_DUTY);
                        if (!r_emer) begin
                            e.left_duty = n_lspd;
                            e.right_duty = n_rspd;
                        end
                        n_stage[k] = e;
                        k = k + 2'd1;
                    end
                    if ((r_now - r_lst) > r_sto) begin
                        if (!r_sval[0]) begin
                            n_stage[k] = mk(RK_LDISC);
                            k = k + 2'd1;
                        end
                        if (!r_sval[1]) begin
                            n_stage[k] = mk(RK_RDISC);
                            k = k + 2'd1;
                        end
                    end
                    n_duty_sent = 1'b0;
                end
                ACT_LEFT, ACT_RIGHT: begin
                    n_stemp[s] = r_itemp;
                    n_scur[s] = r_icur;
                    n_scode[s] = r_istat;
                    n_stacho[s] = r_itacho;
                    n_sval[s] = 1'b1;
                    if (r_sval[~s]) begin
                        n_lst = r_now;
                        e = mk(RK_LSTAT);
                        e.temp = n_stemp[0];
                        e.curr = n_scur[0];
                        e.status = n_scode[0];
                        n_stage[0] = e;
                        e = mk(RK_RSTAT);
                        e.temp = n_stemp[1];
                        e.curr = n_scur[1];
                        e.status = n_scode[1];
                        n_stage[1] = e;
                        k = 2'd2;
                        if (r_pvalid && (r_tpm != '0) && (dt != '0)) begin
                            dl = n_stacho[0] - r_ptacho[0];
                            dr = n_stacho[1] - r_ptacho[1];
                            e = mk(RK_ODOM);
                            e.d_fwd = 34'(dl) - 34'(dr);
                            e.d_rot = -(34'(dl) + 34'(dr));
                            e.dt = dt;
                            e.tpm = r_tpm;
                            e.left_ticks = n_stacho[0];
                            e.right_ticks = n_stacho[1];
                            n_stage[2] = e;
                            k = 2'd3;
                        end
                        n_pvalid = 1'b1;
                        n_ptacho[0] = n_stacho[0];
                        n_ptacho[1] = n_stacho[1];
                        n_ptime = r_now;
                        n_sval = 2'b00;
                    end
                end
                ACT_EMERG: begin
                    if (r_emer) begin
                        n_lspd = '0;
                        n_rspd = '0;
                        n_stage[0] = mk(RK_DUTY);
                        k = 2'd1;
                        n_duty_sent = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (k != 2'd0) n_stage[k - 2'd1].last = 1'b1;
        end
        n_cnt = k;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_EVAL;
            F_EVAL: n_state = (n_cnt == 2'd0) ? F_IDLE : F_EMIT;
            F_EMIT: if (!i_full && (r_idx == r_cnt - 2'd1)) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_EMIT) && !i_full;
        o_job   = r_stage[r_idx];
    end

    // Capture the item and its mixer product
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_act    <= i_action;
            r_now    <= i_data[31:0];
            r_lin    <= i_data[63:32];
            r_emer   <= i_data[96];
            r_itemp  <= i_data[112:97];
            r_icur   <= i_data[128:113];
            r_istat  <= i_data[132:129];
            r_itacho <= i_data[164:133];
            r_p      <= $signed({1'b0, r_wd}) * $signed(i_data[95:64]);
        end
        if (r_state == F_EVAL) r_stage <= n_stage;
    end

    // Hold configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt <= '0;
            r_idx <= '0;
            r_wd <= '0;
            r_tpm <= '0;
            r_cto <= TIMEOUT_RESET;
            r_sto <= TIMEOUT_RESET;
            r_lspd <= '0;
            r_rspd <= '0;
            r_duty_sent <= 1'b0;
            r_lct <= '0;
            r_lst <= '0;
            r_sval <= '0;
            r_stemp <= '{default: '0};
            r_scur <= '{default: '0};
            r_scode <= '{default: '0};
            r_stacho <= '{default: '0};
            r_pvalid <= 1'b0;
            r_ptacho <= '{default: '0};
            r_ptime <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WHEEL_DIST: r_wd <= i_cfg_data[23:0];
                    CFG_TPM:        r_tpm <= i_cfg_data;
                    CFG_CMD_TO:     r_cto <= i_cfg_data;
                    CFG_STAT_TO:    r_sto <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == F_EVAL) begin
                r_cnt <= n_cnt;
                r_idx <= '0;
                r_lspd <= n_lspd;
                r_rspd <= n_rspd;
                r_duty_sent <= n_duty_sent;
                r_lct <= n_lct;
                r_lst <= n_lst;
                r_sval <= n_sval;
                r_stemp <= n_stemp;
                r_scur <= n_scur;
                r_scode <= n_scode;
                r_stacho <= n_stacho;
                r_pvalid <= n_pvalid;
                r_ptacho <= n_ptacho;
                r_ptime <= n_ptime;
            end else if (o_push) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ----- sv/ddmo_back.sv -----
// Back part: velocity divider and the registered result stage.
module ddmo_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ddmo_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_kind,
    output logic           o_last,
    output logic [ddmo_pkg::OUT_DATA_W-1:0] o_data
);
    import ddmo_pkg::*;

    localparam int NUM_W = 85;
    localparam logic [19:0] MICROS = 20'd1000000;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [63:0] r_den, r_rem_f, r_rem_r;
    logic [NUM_W-1:0] r_num_f, r_num_r;
    logic [32:0] r_q_f, r_q_r;
    logic        r_ovf_f, r_ovf_r, r_neg_f, r_neg_r;
    logic [6:0]  r_step;
    logic        r_ov;
    logic [2:0]  r_ok;
    logic        r_ol;
    logic [OUT_DATA_W-1:0] r_od;

    logic        w_free, w_plain, w_load_plain, w_load_odo;
    logic [33:0] w_mag_f, w_mag_r;
    logic [64:0] w_r2_f, w_r2_r;
    logic        w_ge_f, w_ge_r;
    logic [31:0] w_fwd, w_rot;

    function automatic logic [31:0] sat(input logic [32:0] q, input logic ovf, input logic neg);
        logic [32:0] lim, qs;
        begin
            lim = neg ? 33'h080000000 : 33'h07FFFFFFF;
            qs = (ovf || (q > lim)) ? lim : q;
            sat = neg ? (32'd0 - qs[31:0]) : qs[31:0];
        end
    endfunction

    assign w_free  = !r_ov || i_ready;
    assign w_plain = !i_empty && (i_job.kind != RK_ODOM);
    assign w_mag_f = r_job.d_fwd[33] ? 34'(-r_job.d_fwd) : 34'(r_job.d_fwd);
    assign w_mag_r = r_job.d_rot[33] ? 34'(-r_job.d_rot) : 34'(r_job.d_rot);

    // One restoring step on each lane
    assign w_r2_f = {r_rem_f, r_num_f[NUM_W-1]};
    assign w_r2_r = {r_rem_r, r_num_r[NUM_W-1]};
    assign w_ge_f = w_r2_f >= {1'b0, r_den};
    assign w_ge_r = w_r2_r >= {1'b0, r_den};
    assign w_fwd  = sat(r_q_f, r_ovf_f, r_neg_f);
    assign w_rot  = sat(r_q_r, r_ovf_r, r_neg_r);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty && (i_job.kind == RK_ODOM)) n_state = B_MUL;
            B_MUL:  n_state = B_DIV;
            B_DIV:  if (r_step == 7'(NUM_W - 1)) n_state = B_SEND;
            B_SEND: if (w_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Queue pop and output loads
    always_comb begin
        w_load_plain = (r_state == B_IDLE) && w_plain && w_free;
        w_load_odo   = (r_state == B_SEND) && w_free;
        o_pop = w_load_plain || ((r_state == B_IDLE) && !i_empty && (i_job.kind == RK_ODOM));
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && !i_empty) r_job <= i_job;
        if (r_state == B_MUL) begin
            r_den   <= r_job.dt * r_job.tpm;
            r_num_f <= {54'(w_mag_f * MICROS), 31'd0};
            r_num_r <= {54'(w_mag_r * MICROS), 31'd0};
            r_neg_f <= r_job.d_fwd[33];
            r_neg_r <= r_job.d_rot[33];
            r_rem_f <= '0;
            r_rem_r <= '0;
            r_q_f   <= '0;
            r_q_r   <= '0;
            r_ovf_f <= 1'b0;
            r_ovf_r <= 1'b0;
            r_step  <= '0;
        end else if (r_state == B_DIV) begin
            r_num_f <= r_num_f << 1;
            r_num_r <= r_num_r << 1;
            r_rem_f <= w_ge_f ? 64'(w_r2_f - {1'b0, r_den}) : w_r2_f[63:0];
            r_rem_r <= w_ge_r ? 64'(w_r2_r - {1'b0, r_den}) : w_r2_r[63:0];
            r_q_f   <= {r_q_f[31:0], w_ge_f};
            r_q_r   <= {r_q_r[31:0], w_ge_r};
            r_ovf_f <= r_ovf_f | r_q_f[32];
            r_ovf_r <= r_ovf_r | r_q_r[32];
            r_step  <= r_step + 7'd1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_load_plain) begin
            r_ok <= i_job.kind;
            r_ol <= i_job.last;
            r_od <= {4'd0, i_job.right_ticks, i_job.left_ticks, 32'd0, 32'd0, i_job.status,
                     i_job.curr, i_job.temp, i_job.right_duty, i_job.left_duty};
        end else if (w_load_odo) begin
            r_ok <= r_job.kind;
            r_ol <= r_job.last;
            r_od <= {4'd0, r_job.right_ticks, r_job.left_ticks, w_rot, w_fwd, 4'd0,
                     16'd0, 16'd0, 16'd0, 16'd0};
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_plain || w_load_odo) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_ok;
    assign o_last  = r_ol;
    assign o_data  = r_od;

endmodule

// ----- sv/diff_drive_mixer_odometry.sv -----
// Top level of the differential-drive mixer with status pairing and odometry.
// Input stream: tuser carries the action (twist, tick, left status, right
// status, emergency); tdata carries the item's other fields. Each accepted
// item gives zero to three reports on the output stream, the last one
// flagged with tlast; tuser carries the report kind.
// The front part takes one item at a time: it accepts the item, evaluates
// it, then pushes its reports one per cycle into a four-entry queue while
// the queue is not full.
// The back part forwards one plain report per cycle while the output is not
// stalled. An odometry report goes through a multiply state and an 85-step
// restoring divider that runs both velocity lanes side by side.
// While the output is stalled the back part holds its result register, the
// queue fills and then the front part stops taking items.
// Reset (synchronous, active low) clears control and block state, loads both
// timeouts with one second; configuration writes take effect on the next edge.
module diff_drive_mixer_odometry (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_us, linear_cmd, angular_cmd, emergency_level, pcb_temperature,
    // input_current, motor_status, tacho_count, zero pad
    input  logic [ddmo_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_duty, right_duty, report_temperature, report_current, report_status,
    // forward_velocity, rotation_velocity, left_tick_report, right_tick_report, pad
    output logic [ddmo_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // report_kind
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import ddmo_pkg::*;

    logic w_push, w_full, w_pop, w_empty;
    t_job w_wjob, w_rjob;

    ddmo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_action(s_axis_tuser), .i_data(s_axis_tdata),
        .o_push(w_push), .o_job(w_wjob), .i_full(w_full)
    );

    ddmo_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_wdata(w_wjob), .o_full(w_full),
        .i_pop(w_pop), .o_rdata(w_rjob), .o_empty(w_empty)
    );

    ddmo_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job(w_rjob), .i_empty(w_empty), .o_pop(w_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_last(m_axis_tlast), .o_data(m_axis_tdata)
    );

    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("request pushed into full queue");

    // Odometry is always the final report of its item
    a_odom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == RK_ODOM)) |-> m_axis_tlast)
        else $error("odometry report without tlast");

    // One item at a time in the front part
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken during evaluation");

endmodule

// ----- dv/diff_drive_mixer_odometry_test.sv -----
// Self-checking stream testbench for the differential-drive mixer and odometry block.
`timescale 1ns / 1ps

module diff_drive_mixer_odometry_test;
    import ddmo_pkg::*;

    typedef struct {
        bit [2:0]  action;
        bit [31:0] now_us;
        bit [31:0] linear_cmd;
        bit [31:0] angular_cmd;
        bit        emergency;
        bit [15:0] temperature;
        bit [15:0] current;
        bit [3:0]  status;
        bit [31:0] tacho;
    } request_t;

    typedef struct packed {
        bit [2:0]  kind;
        bit [15:0] left_duty;
        bit [15:0] right_duty;
        bit [15:0] temperature;
        bit [15:0] current;
        bit [3:0]  status;
        bit [31:0] fwd_vel;
        bit [31:0] rot_vel;
        bit [31:0] left_ticks;
        bit [31:0] right_ticks;
        bit        last;
    } report_t;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_idx = '0;
    logic [31:0]           i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    diff_drive_mixer_odometry i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state and configuration copy
    bit [23:0] wheel_dist = '0;
    bit [31:0] tpm = '0;
    bit [31:0] cmd_timeout = TIMEOUT_RESET;
    bit [31:0] stat_timeout = TIMEOUT_RESET;
    bit [15:0] left_speed = '0, right_speed = '0;
    bit        duty_sent = 1'b0;
    bit [31:0] last_cmd_time = '0, last_stat_time = '0;
    bit        side_valid [2] = '{0, 0};
    bit [15:0] side_temp [2] = '{0, 0};
    bit [15:0] side_curr [2] = '{0, 0};
    bit [3:0]  side_code [2] = '{0, 0};
    bit [31:0] side_tacho [2] = '{0, 0};
    bit        prev_valid = 1'b0;
    bit [31:0] prev_tacho [2] = '{0, 0};
    bit [31:0] prev_time = '0;

    request_t pending_requests[$];
    report_t  expected_reports[$];
    request_t cur_req;
    int       mismatches = 0;
    int       send_gap = 0;
    bit       req_taken = 1'b0;
    bit       sender_hold = 1'b0;
    bit       receiver_hold_req = 1'b0;
    int       idle_cycles = 0;
    bit [31:0] clock_us = 32'd100;
    bit [31:0] tacho_pos [2] = '{0, 0};

    // Clamp and truncate a Q.33 sum to Q2.14
    function automatic bit [15:0] duty_of(longint s);
        if (s >= (64'sd1 <<< 33)) return 16'sd16384;
        if (s <= -(64'sd1 <<< 33)) return -16'sd16384;
        return 16'(s / 524288);
    endfunction

    // Scaled velocity quotient, truncated and saturated to 32-bit signed
    function automatic bit [31:0] velocity_of(longint d, bit [63:0] den);
        bit        neg;
        bit [63:0] mag;
        bit [127:0] num, q, limit;
        neg = d < 0;
        mag = neg ? 64'(-d) : 64'(d);
        num = ({64'b0, mag} * 128'd1000000) << 31;
        q = num / {64'b0, den};
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > limit) q = limit;
        return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    function automatic report_t blank_report(bit [2:0] kind);
        report_t r;
        r = '{default: 0};
        r.kind = kind;
        return r;
    endfunction

    // Compute the reports for one accepted request and update the state
    function automatic void predict_request(request_t q);
        report_t   out[$];
        report_t   r;
        longint    lin, p, dl, dr;
        bit [31:0] dt, diff;
        bit [63:0] den;
        int        s;
        case (q.action)
            ACT_TWIST: begin
                lin = longint'($signed(q.linear_cmd)) * 131072;
                p = longint'(wheel_dist) * longint'($signed(q.angular_cmd));
                last_cmd_time = q.now_us;
                left_speed = duty_of(lin - p);
                right_speed = duty_of(-(lin + p));
                if (!duty_sent) begin
                    r = blank_report(RK_DUTY);
                    if (!q.emergency) begin
                        r.left_duty = left_speed;
                        r.right_duty = right_speed;
                    end
                    out.push_back(r);
                    duty_sent = 1'b1;
                end
            end
            ACT_TICK: begin
                if (q.now_us - last_cmd_time > cmd_timeout) begin
                    left_speed = '0;
                    right_speed = '0;
                end
                if (!duty_sent) begin
                    r = blank_report(RK_DUTY);
                    if (!q.emergency) begin
                        r.left_duty = left_speed;
                        r.right_duty = right_speed;
                    end
                    out.push_back(r);
                end
                if (q.now_us - last_stat_time > stat_timeout) begin
                    if (!side_valid[0]) out.push_back(blank_report(RK_LDISC));
                    if (!side_valid[1]) out.push_back(blank_report(RK_RDISC));
                end
                duty_sent = 1'b0;
            end
            ACT_LEFT, ACT_RIGHT: begin
                s = (q.action == ACT_LEFT) ? 0 : 1;
                side_temp[s] = q.temperature;
                side_curr[s] = q.current;
                side_code[s] = q.status;
                side_tacho[s] = q.tacho;
                side_valid[s] = 1'b1;
                if (side_valid[1 - s]) begin
                    dt = q.now_us - prev_time;
                    last_stat_time = q.now_us;
                    for (int k = 0; k < 2; k++) begin
                        r = blank_report(k == 0 ? RK_LSTAT : RK_RSTAT);
                        r.temperature = side_temp[k];
                        r.current = side_curr[k];
                        r.status = side_code[k];
                        out.push_back(r);
                    end
                    if (prev_valid && tpm != 0 && dt != 0) begin
                        diff = side_tacho[0] - prev_tacho[0];
                        dl = longint'($signed(diff));
                        diff = side_tacho[1] - prev_tacho[1];
                        dr = longint'($signed(diff));
                        den = 64'(dt) * 64'(tpm);
                        r = blank_report(RK_ODOM);
                        r.fwd_vel = velocity_of(dl - dr, den);
                        r.rot_vel = velocity_of(-(dl + dr), den);
                        r.left_ticks = side_tacho[0];
                        r.right_ticks = side_tacho[1];
                        out.push_back(r);
                    end
                    prev_valid = 1'b1;
                    prev_tacho = side_tacho;
                    prev_time = q.now_us;
                    side_valid = '{0, 0};
                end
            end
            ACT_EMERG: begin
                if (q.emergency) begin
                    left_speed = '0;
                    right_speed = '0;
                    out.push_back(blank_report(RK_DUTY));
                    duty_sent = 1'b1;
                end
            end
            default: ;
        endcase
        if (out.size() > 0) out[out.size() - 1].last = 1'b1;
        foreach (out[i]) expected_reports.push_back(out[i]);
    endfunction

    // Request input side: predict on acceptance and flag it for the driver
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_request(cur_req);
        end
    end

    // Drop the taken request, wait out the gap, then load the next one
    always @(negedge i_clk) begin
        logic nv;
        nv = s_axis_tvalid;
        if (req_taken) begin
            send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                     : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
        end
        if (!s_axis_tvalid || req_taken) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
            end else if (i_rst_n && !sender_hold && pending_requests.size() > 0) begin
                cur_req = pending_requests.pop_front();
                s_axis_tuser <= cur_req.action;
                s_axis_tdata <= {3'b0, cur_req.tacho, cur_req.status, cur_req.current,
                                 cur_req.temperature, cur_req.emergency, cur_req.angular_cmd,
                                 cur_req.linear_cmd, cur_req.now_us};
                nv = 1'b1;
            end
        end
        s_axis_tvalid <= nv;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        int hold_left;
        if (receiver_hold_req && hold_left == 0) begin
            hold_left = 400;
            receiver_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each accepted report with the oldest expectation
    always @(posedge i_clk) begin
        report_t exp_r, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind        = m_axis_tuser;
            got.left_duty   = m_axis_tdata[15:0];
            got.right_duty  = m_axis_tdata[31:16];
            got.temperature = m_axis_tdata[47:32];
            got.current     = m_axis_tdata[63:48];
            got.status      = m_axis_tdata[67:64];
            got.fwd_vel     = m_axis_tdata[99:68];
            got.rot_vel     = m_axis_tdata[131:100];
            got.left_ticks  = m_axis_tdata[163:132];
            got.right_ticks = m_axis_tdata[195:164];
            got.last        = m_axis_tlast;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected report: %p", got);
            end else begin
                exp_r = expected_reports.pop_front();
                if (got != exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch\n  expected %p\n  actual   %p", exp_r, got);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL diff_drive_mixer_odometry");
            $finish;
        end
    end

    function automatic request_t make_request(bit [2:0] action);
        request_t q;
        q.action      = action;
        clock_us      = clock_us + (($urandom_range(0, 19) == 0) ? $urandom()
                                                               : $urandom_range(1, 3000));
        q.now_us      = clock_us;
        case ($urandom_range(0, 5))
            0: q.linear_cmd = 32'h7FFF_FFFF;
            1: q.linear_cmd = 32'h8000_0000;
            2: q.linear_cmd = $urandom();
            default: q.linear_cmd = 32'($signed($urandom_range(0, 131072)) - 65536);
        endcase
        case ($urandom_range(0, 5))
            0: q.angular_cmd = 32'h7FFF_FFFF;
            1: q.angular_cmd = 32'h8000_0000;
            2: q.angular_cmd = $urandom();
            default: q.angular_cmd = 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
        q.emergency   = ($urandom_range(0, 6) == 0);
        q.temperature = 16'($urandom());
        q.current     = 16'($urandom());
        q.status      = 4'($urandom());
        q.tacho       = $urandom();
        return q;
    endfunction

    function automatic request_t make_status(int side);
        request_t q;
        q = make_request(side == 0 ? ACT_LEFT : ACT_RIGHT);
        if ($urandom_range(0, 9) == 0) tacho_pos[side] = $urandom();
        else tacho_pos[side] = tacho_pos[side] + 32'($signed($urandom_range(0, 8000)) - 4000);
        q.tacho = tacho_pos[side];
        return q;
    endfunction

    task automatic push_pair();
        if ($urandom_range(0, 1)) begin
            pending_requests.push_back(make_status(0));
            pending_requests.push_back(make_status(1));
        end else begin
            pending_requests.push_back(make_status(1));
            pending_requests.push_back(make_status(0));
        end
    endtask

    // Wait until all requests went out and every report arrived, then settle
    task automatic drain();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_WHEEL_DIST: wheel_dist = value[23:0];
            CFG_TPM:        tpm = value;
            CFG_CMD_TO:     cmd_timeout = value;
            CFG_STAT_TO:    stat_timeout = value;
            default: ;
        endcase
    endtask

    task automatic configure(bit [31:0] wd, bit [31:0] tp, bit [31:0] cto, bit [31:0] sto);
        write_reg(CFG_WHEEL_DIST, wd);
        write_reg(CFG_TPM, tp);
        write_reg(CFG_CMD_TO, cto);
        write_reg(CFG_STAT_TO, sto);
    endtask

    task automatic random_requests(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                push_pair();
                n++;
            end else if (pick < 65) pending_requests.push_back(make_request(ACT_TWIST));
            else if (pick < 88) pending_requests.push_back(make_request(ACT_TICK));
            else if (pick < 94) pending_requests.push_back(make_request(ACT_EMERG));
            else if (pick < 97) pending_requests.push_back(make_status($urandom_range(0, 1)));
            else pending_requests.push_back(make_request(3'($urandom_range(5, 7))));
        end
    endtask

    initial begin
        request_t q;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, mixing extremes, emergency, pairing corners
        configure(32'h0001_0000, 32'h0040_0000, TIMEOUT_RESET, TIMEOUT_RESET);
        pending_requests.push_back(make_request(ACT_TICK));
        q = make_request(ACT_TWIST);
        q.linear_cmd = 32'h7FFF_FFFF; q.angular_cmd = 32'h8000_0000; q.emergency = 0;
        pending_requests.push_back(q);
        q = make_request(ACT_TICK); q.emergency = 0;
        pending_requests.push_back(q);
        q = make_request(ACT_TWIST);
        q.linear_cmd = 32'h8000_0000; q.angular_cmd = 32'h7FFF_FFFF; q.emergency = 1;
        pending_requests.push_back(q);
        q = make_request(ACT_TWIST);
        q.linear_cmd = 32'h0000_8000; q.angular_cmd = 32'hFFFF_0000; q.emergency = 0;
        pending_requests.push_back(q);
        q = make_request(ACT_EMERG); q.emergency = 0;
        pending_requests.push_back(q);
        q = make_request(ACT_EMERG); q.emergency = 1;
        pending_requests.push_back(q);
        push_pair();
        push_pair();
        // another status pair, each stamped with the running clock
        q = make_status(0); q.now_us = clock_us;
        pending_requests.push_back(q);
        q = make_status(1); q.now_us = clock_us;
        pending_requests.push_back(q);
        q = make_status(0); q.tacho = 32'h7FFF_FFFF; pending_requests.push_back(q);
        q = make_status(1); q.tacho = 32'h8000_0000; pending_requests.push_back(q);
        clock_us = clock_us + 32'd2_000_000;
        pending_requests.push_back(make_request(ACT_TICK));
        pending_requests.push_back(make_status(1));
        clock_us = clock_us + 32'd2_000_000;
        pending_requests.push_back(make_request(ACT_TICK));
        pending_requests.push_back(make_request(3'd5));
        pending_requests.push_back(make_request(3'd7));
        drain();

        // Phase: half-meter track, short timeouts, with a long receiver hold-off
        configure(32'h0000_8000, 32'h03E8_0000, 32'd500, 32'd800);
        receiver_hold_req = 1'b1;
        random_requests(50);
        drain();
        // Sender pause mid-run until all reports are in
        sender_hold = 1'b1;
        random_requests(40);
        repeat (20) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        sender_hold = 1'b0;
        drain();

        // Phase: maximum settings, zero timeouts
        configure(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        random_requests(85);
        drain();

        // Phase: zero track, smallest nonzero scale, maximum timeouts
        configure(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_requests(85);
        drain();

        // Phase: random settings
        configure($urandom(), $urandom_range(1, 32'h00FF_FFFF), $urandom_range(0, 5000),
                  $urandom_range(0, 5000));
        random_requests(85);
        drain();

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS diff_drive_mixer_odometry");
        else
            $display("FAIL diff_drive_mixer_odometry");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ddmo_pkg.sv
sv/ddmo_queue.sv
sv/ddmo_front.sv
sv/ddmo_back.sv
sv/diff_drive_mixer_odometry.sv
dv/diff_drive_mixer_odometry_test.sv
